/* rtl/core/scfc_pkg.sv */
// ----------------------------------------------------------------------------
// scfc_pkg
// Shared types and constants of the free-block cache.
// ----------------------------------------------------------------------------
package scfc_pkg;

    localparam int Capacity    = 64;
    localparam int AddressBits = 32;
    localparam int SizeBits    = 32;
    localparam int IdxBits     = $clog2(Capacity);
    localparam int CntBits     = $clog2(Capacity + 1);

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_TAKE   = 2'd2,
        MODE_PEEK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // one table entry as held in memory
    typedef struct packed {
        logic [AddressBits-1:0] address;
        logic [SizeBits-1:0]    size;
        logic                   cls;
        logic [IdxBits-1:0]     rank;
    } entry_t;

    // memory port driven by the controller
    typedef struct packed {
        logic               rd_en;
        logic [IdxBits-1:0] rd_addr;
        logic               wr_en;
        logic [IdxBits-1:0] wr_addr;
        entry_t             wr_data;
    } mem_req_t;

endpackage

/* rtl/core/scfc_table.sv */
// ----------------------------------------------------------------------------
// scfc_table
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scfc_table (
    input  logic              clk,
    input  scfc_pkg::mem_req_t req,
    output scfc_pkg::entry_t   rd_data
);
    import scfc_pkg::*;

    entry_t mem [Capacity];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

/* rtl/core/scfc_ctrl.sv */
// ----------------------------------------------------------------------------
// scfc_ctrl
// Sequencer: scans for oldest match; remove/take hits sweep ranks down.
// ----------------------------------------------------------------------------
module scfc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  scfc_pkg::mode_t               in_mode,
    input  logic [scfc_pkg::AddressBits-1:0] in_address,
    input  logic [scfc_pkg::SizeBits-1:0] in_size,
    input  logic                          in_cls,
    output logic                          out_valid,
    input  logic                          out_ready,
    output scfc_pkg::status_t             out_status,
    output logic [31:0]                   out_address,
    output scfc_pkg::mem_req_t            req,
    input  scfc_pkg::entry_t              rd_data
);
    import scfc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SWEEP, S_RESULT
    } state_t;

    state_t               state_reg;
    logic [Capacity-1:0]  valid_reg;
    logic [CntBits-1:0]   live_reg;
    mode_t                mode_reg;
    logic [AddressBits-1:0] addr_reg;
    logic [SizeBits-1:0]  size_reg;
    logic                 cls_reg;
    logic [CntBits-1:0]   scan_reg;   // issued read index
    logic                 rd_pend_reg;
    logic [IdxBits-1:0]   rd_idx_reg;
    logic                 hit_reg;
    logic [IdxBits-1:0]   hit_idx_reg;
    logic [IdxBits-1:0]   hit_rank_reg;
    logic [AddressBits-1:0] hit_addr_reg;
    status_t              status_reg;
    logic [31:0]          res_addr_reg;
    logic                 out_valid_reg;

    logic [IdxBits-1:0]   free_idx;
    logic                 free_found;
    logic                 match;
    logic [AddressBits-1:0] res_wide;

    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = Capacity - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx   = IdxBits'(i);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        match = valid_reg[rd_idx_reg];
        if (mode_reg != MODE_PEEK)
        begin
            match = match && rd_data.size == size_reg && rd_data.cls == cls_reg;
        end
        if (mode_reg == MODE_REMOVE)
        begin
            match = match && rd_data.address == addr_reg;
        end
    end

    assign res_wide = (mode_reg == MODE_REMOVE) ? '0 : hit_addr_reg;

    always_comb
    begin
        req         = '0;
        req.rd_addr = scan_reg[IdxBits-1:0];
        req.rd_en   = (state_reg == S_SCAN || state_reg == S_SWEEP)
                      && scan_reg < CntBits'(Capacity);
        // rank decrement during the sweep
        if (state_reg == S_SWEEP && rd_pend_reg && valid_reg[rd_idx_reg]
            && rd_data.rank > hit_rank_reg)
        begin
            req.wr_en        = 1'b1;
            req.wr_addr      = rd_idx_reg;
            req.wr_data      = rd_data;
            req.wr_data.rank = rd_data.rank - 1'b1;
        end
        if (state_reg == S_IDLE && in_valid && in_ready && in_mode == MODE_ADD
            && free_found)
        begin
            req.wr_en           = 1'b1;
            req.wr_addr         = free_idx;
            req.wr_data.address = in_address;
            req.wr_data.size    = in_size;
            req.wr_data.cls     = in_cls;
            req.wr_data.rank    = live_reg[IdxBits-1:0];
        end
    end

    assign in_ready    = state_reg == S_IDLE && !out_valid_reg;
    assign out_valid   = out_valid_reg;
    assign out_status  = status_reg;
    assign out_address = res_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            scan_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_pend_reg <= req.rd_en;
            rd_idx_reg  <= req.rd_addr;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        mode_reg <= in_mode;
                        addr_reg <= in_address;
                        size_reg <= in_size;
                        cls_reg  <= in_cls;
                        hit_reg  <= 1'b0;
                        scan_reg <= '0;
                        if (in_mode == MODE_ADD)
                        begin
                            out_valid_reg <= 1'b1;
                            res_addr_reg  <= '0;
                            if (free_found)
                            begin
                                valid_reg[free_idx] <= 1'b1;
                                live_reg            <= live_reg + 1'b1;
                                status_reg          <= ST_DONE;
                            end
                            else
                            begin
                                status_reg <= ST_FULL;
                            end
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (req.rd_en)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    if (rd_pend_reg && match
                        && (!hit_reg || rd_data.rank < hit_rank_reg))
                    begin
                        hit_reg      <= 1'b1;
                        hit_idx_reg  <= rd_idx_reg;
                        hit_rank_reg <= rd_data.rank;
                        hit_addr_reg <= rd_data.address;
                    end
                    if (!req.rd_en && !rd_pend_reg)
                    begin
                        scan_reg <= '0;
                        if (hit_reg && mode_reg != MODE_PEEK)
                        begin
                            valid_reg[hit_idx_reg] <= 1'b0;
                            live_reg               <= live_reg - 1'b1;
                            state_reg              <= S_SWEEP;
                        end
                        else
                        begin
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_SWEEP:
                begin
                    if (req.rd_en)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    if (!req.rd_en && !rd_pend_reg)
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    out_valid_reg <= 1'b1;
                    status_reg    <= hit_reg ? ST_DONE : ST_NONE;
                    res_addr_reg  <= hit_reg ? 32'(res_wide) : '0;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CntBits'(Capacity))
        else $error("live count above capacity");
    a_live_pop: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg == CntBits'($countones(valid_reg)))
        else $error("live count and valid bits disagree");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("input ready while busy");
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_FULL |-> res_addr_reg == '0)
        else $error("full status with an address");

endmodule

/* rtl/core/size_class_fifo_free_block_cache_unit.sv */
// ----------------------------------------------------------------------------
// size_class_fifo_free_block_cache_unit
// FIFO-ordered free-block cache keyed by size and cache class.
// ----------------------------------------------------------------------------
// Input stream s_axis: one operation per transfer (mode in tuser, block
// address, size and class in tdata). Output stream m_axis: one result per
// operation, status in tuser, address in tdata.
// Add: result valid in the cycle after the input transfer. Remove, take and peek
// scan the entry memory one entry per cycle; a successful remove or take then
// sweeps the memory again to close the rank gap, before the result is loaded.
// The single read port of the entry memory sets the pace of both passes.
// Reset empties the table at once (valid bits in flops); no clearing pass.
// A result waits in the output register while m_axis_tready is low; no new
// item is taken until it has been transferred.
// ----------------------------------------------------------------------------
module size_class_fifo_free_block_cache_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // block_address, block_size, cache_class
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result_address
    output logic [1:0]  m_axis_tuser    // status
);
    import scfc_pkg::*;

    mem_req_t req;
    entry_t   rd_data;
    status_t  st;

    scfc_table u_table (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    scfc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_mode     (mode_t'(s_axis_tuser)),
        .in_address  (s_axis_tdata[31:0]),
        .in_size     (s_axis_tdata[63:32]),
        .in_cls      (s_axis_tdata[64]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (st),
        .out_address (m_axis_tdata),
        .req         (req),
        .rd_data     (rd_data)
    );

    assign m_axis_tuser = st;

endmodule
